/* rtl/core/sbt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo matching cost package
// Shared widths, register indexes, payload types and small pixel helpers.
// ----------------------------------------------------------------------------
package sbt_pkg;

   localparam int PIX_W            = 8;
   localparam int NUM_CH           = 3;
   localparam int COST_W           = 16;
   localparam int SUM_W            = 18;
   localparam int DISP_W           = 5;
   localparam int COL_W            = 6;
   localparam int NUMC_W           = 2;
   localparam int NUMD_W           = 6;
   localparam int TRUNC_W          = 8;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 8;
   localparam int DEFAULT_MAX_DISP = 32;

   localparam logic [COL_W-1:0]   COL_MAX       = 6'd63;
   localparam logic               USE_BT_RST    = 1'b1;
   localparam logic               USE_SQ_RST    = 1'b0;
   localparam logic [TRUNC_W-1:0] TRUNC_RST     = 8'd255;
   localparam logic [NUMC_W-1:0]  NUM_COLOR_RST = 2'd3;
   localparam logic [NUMD_W-1:0]  NUM_DISP_RST  = 6'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_USE_BT     = 3'd0,
      REG_USE_SQ     = 3'd1,
      REG_TRUNC      = 3'd2,
      REG_NUM_COLORS = 3'd3,
      REG_NUM_DISP   = 3'd4
   } csr_reg_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [NUM_CH-1:0] rgb_type;

   typedef struct packed {
      rgb_type c1;
      rgb_type mn1;
      rgb_type mx1;
   } left_stats_type;

   typedef struct packed {
      logic                valid;
      logic                emit;
      logic [DISP_W-1:0]   disp;
      logic                bad;
      logic                l2_center;
      logic                r2_center;
      logic                pixel_last;
      logic                row_last;
      left_stats_type      left;
   } issue_type;

   typedef struct packed {
      logic                use_bt;
      logic                use_sq;
      logic [NUMC_W-1:0]   num_ch;
      logic [NUMD_W-1:0]   num_disp;
      logic [COST_W-1:0]   maxsum;
   } cfg_type;

   function automatic pix_type avg2(input pix_type a, input pix_type b);
      logic [PIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PIX_W:1];
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      pix_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      pix_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/sbt_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Column request channel
// Carries one left and one right pixel column and the row-end flag.
// ----------------------------------------------------------------------------
interface sbt_req_if;
   import sbt_pkg::*;

   logic    valid;
   logic    ready;
   pix_type left_c0;
   pix_type left_c1;
   pix_type left_c2;
   pix_type right_c0;
   pix_type right_c1;
   pix_type right_c2;
   logic    row_end;

   modport source (
      output valid, left_c0, left_c1, left_c2, right_c0, right_c1, right_c2, row_end,
      input  ready
   );

   modport sink (
      input  valid, left_c0, left_c1, left_c2, right_c0, right_c1, right_c2, row_end,
      output ready
   );

endinterface
`default_nettype wire

/* rtl/core/sbt_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Cost response channel
// Carries one disparity cost with its pixel and row markers.
// ----------------------------------------------------------------------------
interface sbt_rsp_if;
   import sbt_pkg::*;

   logic              valid;
   logic              ready;
   logic [DISP_W-1:0] disparity;
   logic [COST_W-1:0] cost;
   logic              pixel_last;
   logic              row_last;

   modport source (
      output valid, disparity, cost, pixel_last, row_last,
      input  ready
   );

   modport sink (
      input  valid, disparity, cost, pixel_last, row_last,
      output ready
   );

endinterface
`default_nettype wire

/* rtl/core/stereo_bt_matching_cost_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo matching cost unit
// Streams rectified pixel columns and emits a Birchfield-Tomasi or absolute
// difference cost, optionally squared, for every disparity of every pixel.
//
// Channel    Dir  Payload                                       Transaction
// req_chan   in   left_c0..2, right_c0..2, row_end              one column
// rsp_chan   out  disparity, cost, pixel_last, row_last         one cost
// csr_*      in   csr_index, csr_wdata (write enable csr_wr_en)  one register
//
// Each pixel that a column completes walks its N disparities, N being the
// disparity count, through the single read port of the right window memory
// (one right column per cycle while the output is not stalled, two to prime
// the three-column window). Reset is synchronous; the window memory is not
// cleared. A low rsp ready while a cost is held freezes the whole cost
// pipeline and the window reads.
// ----------------------------------------------------------------------------
module stereo_bt_matching_cost_unit #(
   parameter int MAX_DISP = sbt_pkg::DEFAULT_MAX_DISP
) (
   input  logic                               clock,
   input  logic                               reset,
   sbt_req_if.sink                            req_chan,
   sbt_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [sbt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sbt_pkg::*;

   logic                 use_bt_ff, use_bt_in;
   logic                 use_sq_ff, use_sq_in;
   logic [TRUNC_W-1:0]   trunc_ff, trunc_in;
   logic [NUMC_W-1:0]    num_colors_ff, num_colors_in;
   logic [NUMD_W-1:0]    num_disp_ff, num_disp_in;
   logic [NUMC_W-1:0]    nc_eff;
   logic [COST_W-1:0]    maxsum_ff, maxsum_in;
   cfg_type              cfg;
   issue_type            s1;
   rgb_type              rd_data;
   logic                 adv;

   always_comb begin
      use_bt_in     = use_bt_ff;
      use_sq_in     = use_sq_ff;
      trunc_in      = trunc_ff;
      num_colors_in = num_colors_ff;
      num_disp_in   = num_disp_ff;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_USE_BT: begin
               use_bt_in = csr_wdata[0];
            end
            REG_USE_SQ: begin
               use_sq_in = csr_wdata[0];
            end
            REG_TRUNC: begin
               trunc_in = csr_wdata[TRUNC_W-1:0];
            end
            REG_NUM_COLORS: begin
               num_colors_in = csr_wdata[NUMC_W-1:0];
            end
            REG_NUM_DISP: begin
               num_disp_in = csr_wdata[NUMD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_bt_ff     <= USE_BT_RST;
         use_sq_ff     <= USE_SQ_RST;
         trunc_ff      <= TRUNC_RST;
         num_colors_ff <= NUM_COLOR_RST;
         num_disp_ff   <= NUM_DISP_RST;
      end else begin
         use_bt_ff     <= use_bt_in;
         use_sq_ff     <= use_sq_in;
         trunc_ff      <= trunc_in;
         num_colors_ff <= num_colors_in;
         num_disp_ff   <= num_disp_in;
      end
   end

   // The truncation limit is also the cost of a disparity outside the row.
   assign nc_eff    = (num_colors_ff == '0) ? NUMC_W'(1) : num_colors_ff;
   assign maxsum_in = use_sq_ff ? COST_W'(trunc_ff) * COST_W'(trunc_ff) :
                                  COST_W'(nc_eff) * COST_W'(trunc_ff);

   always_ff @(posedge clock) begin
      maxsum_ff <= maxsum_in;
   end

   assign cfg.use_bt   = use_bt_ff;
   assign cfg.use_sq   = use_sq_ff;
   assign cfg.num_ch   = nc_eff;
   assign cfg.num_disp = num_disp_ff;
   assign cfg.maxsum   = maxsum_ff;

   sbt_seq #(
      .MAX_DISP (MAX_DISP)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .cfg     (cfg),
      .adv     (adv),
      .s1_out  (s1),
      .rd_data (rd_data)
   );

   sbt_cost_pipe u_cost_pipe (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .s1      (s1),
      .rd_data (rd_data),
      .rsp     (rsp_chan),
      .adv     (adv)
   );

endmodule
`default_nettype wire

/* rtl/core/sbt_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Column sequencer and right window memory
// Takes column transactions, keeps the left history and the row position,
// stores right columns in a circular memory and walks the disparities of
// each pixel, reading one right column per cycle while the cost pipe advances.
// ----------------------------------------------------------------------------
module sbt_seq #(
   parameter int MAX_DISP = sbt_pkg::DEFAULT_MAX_DISP
) (
   input  logic                clock,
   input  logic                reset,
   sbt_req_if.sink             req,
   input  sbt_pkg::cfg_type    cfg,
   input  logic                adv,
   output sbt_pkg::issue_type  s1_out,
   output sbt_pkg::rgb_type    rd_data
);
   import sbt_pkg::*;

   localparam int AW    = $clog2(MAX_DISP + 2);
   localparam int DEPTH = 2 ** AW;

   rgb_type            mem [DEPTH];
   rgb_type            rd_data_ff;
   issue_type          s1_ff;
   issue_type          issue;

   logic [AW-1:0]      wptr_ff, wptr_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      nd_eff;
   logic [AW-1:0]      raddr;
   logic [COL_W-1:0]   col_cnt_ff, col_cnt_in;
   logic [COL_W-1:0]   pix_p_ff, pix_p_in;
   logic [COL_W-1:0]   p_cur;
   logic [COL_W-1:0]   disp_ext;
   logic [DISP_W-1:0]  disp;
   logic               pend_ff, pend_in;
   logic               nc_job_ff, nc_job_in;
   logic               cur_job_ff, cur_job_in;
   logic               busy, b_sel, last_k, accept, p_zero;
   rgb_type            lh0_ff, lh1_ff, lh2_ff;
   rgb_type            lh0_in, lh1_in, lh2_in;
   rgb_type            left_in, right_in;
   rgb_type            l1, r1, cl;

   assign busy      = nc_job_ff || cur_job_ff;
   assign req.ready = !busy;
   assign accept    = req.valid && !busy;
   assign b_sel     = nc_job_ff;
   assign left_in   = {req.left_c2, req.left_c1, req.left_c0};
   assign right_in  = {req.right_c2, req.right_c1, req.right_c0};

   assign nd_eff = (cfg.num_disp == '0) ? AW'(1) :
                   (cfg.num_disp > NUMD_W'(MAX_DISP)) ? AW'(MAX_DISP) : AW'(cfg.num_disp);
   assign last_k   = (k_ff == nd_eff + AW'(1));
   assign p_cur    = b_sel ? pix_p_ff - COL_W'(1) : pix_p_ff;
   assign p_zero   = (p_cur == '0);
   assign disp     = DISP_W'(k_ff - AW'(2));
   assign disp_ext = COL_W'(disp);
   assign raddr    = wptr_ff + AW'(1) - AW'(b_sel) - k_ff;

   always_comb begin
      wptr_in    = wptr_ff;
      k_in       = k_ff;
      col_cnt_in = col_cnt_ff;
      pix_p_in   = pix_p_ff;
      pend_in    = pend_ff;
      nc_job_in  = nc_job_ff;
      cur_job_in = cur_job_ff;
      lh0_in     = lh0_ff;
      lh1_in     = lh1_ff;
      lh2_in     = lh2_ff;
      if (accept) begin
         wptr_in    = wptr_ff + AW'(1);
         lh0_in     = left_in;
         lh1_in     = lh0_ff;
         lh2_in     = lh1_ff;
         nc_job_in  = pend_ff && (col_cnt_ff != '0);
         cur_job_in = req.row_end;
         pix_p_in   = col_cnt_ff;
         if (req.row_end) begin
            col_cnt_in = '0;
            pend_in    = 1'b0;
         end else begin
            col_cnt_in = (col_cnt_ff == COL_MAX) ? COL_MAX : col_cnt_ff + COL_W'(1);
            pend_in    = 1'b1;
         end
      end else if (busy && adv) begin
         if (last_k) begin
            k_in = '0;
            if (b_sel) begin
               nc_job_in = 1'b0;
            end else begin
               cur_job_in = 1'b0;
            end
         end else begin
            k_in = k_ff + AW'(1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         cl[i] = b_sel ? lh2_ff[i] : lh1_ff[i];
         issue.left.c1[i] = b_sel ? lh1_ff[i] : lh0_ff[i];
         l1[i] = p_zero ? issue.left.c1[i] : avg2(issue.left.c1[i], cl[i]);
         r1[i] = b_sel ? avg2(issue.left.c1[i], lh0_ff[i]) : issue.left.c1[i];
         issue.left.mn1[i] = min3(issue.left.c1[i], l1[i], r1[i]);
         issue.left.mx1[i] = max3(issue.left.c1[i], l1[i], r1[i]);
      end
      issue.valid      = busy;
      issue.emit       = (k_ff >= AW'(2));
      issue.disp       = disp;
      issue.bad        = disp_ext > p_cur;
      issue.l2_center  = disp_ext == p_cur;
      issue.r2_center  = !b_sel && (disp == '0);
      issue.pixel_last = last_k;
      issue.row_last   = last_k && !b_sel;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wptr_in] <= right_in;
      end
      if (busy && adv) begin
         rd_data_ff <= mem[raddr];
      end
      lh0_ff   <= lh0_in;
      lh1_ff   <= lh1_in;
      lh2_ff   <= lh2_in;
      pix_p_ff <= pix_p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         k_ff       <= '0;
         col_cnt_ff <= '0;
         pend_ff    <= 1'b0;
         nc_job_ff  <= 1'b0;
         cur_job_ff <= 1'b0;
         s1_ff      <= '0;
      end else begin
         wptr_ff    <= wptr_in;
         k_ff       <= k_in;
         col_cnt_ff <= col_cnt_in;
         pend_ff    <= pend_in;
         nc_job_ff  <= nc_job_in;
         cur_job_ff <= cur_job_in;
         if (adv) begin
            s1_ff <= issue;
         end
      end
   end

   assign s1_out  = s1_ff;
   assign rd_data = rd_data_ff;

   a_idle_k: assert property (@(posedge clock) disable iff (reset)
      !busy |-> k_ff == '0)
      else $error("Disparity counter is not at zero while the sequencer is idle.");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> k_ff <= nd_eff + AW'(1))
      else $error("Disparity counter ran past the last read of the pixel.");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      accept && req.row_end |=> cur_job_ff && col_cnt_ff == '0 && !pend_ff)
      else $error("Row end did not queue the last pixel and restart the row.");

   a_pending: assert property (@(posedge clock) disable iff (reset)
      accept && pend_ff && col_cnt_ff != '0 |=> nc_job_ff && k_ff == '0)
      else $error("Waiting pixel was not queued when its right neighbor arrived.");

endmodule
`default_nettype wire

/* rtl/core/sbt_cost_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Cost datapath
// Builds the right interpolants from the last three right columns, forms
// the per-channel dissimilarity, squares it when enabled, sums and
// truncates it, and holds the result in the output register.
// ----------------------------------------------------------------------------
module sbt_cost_pipe (
   input  logic                clock,
   input  logic                reset,
   input  sbt_pkg::cfg_type    cfg,
   input  sbt_pkg::issue_type  s1,
   input  sbt_pkg::rgb_type    rd_data,
   sbt_rsp_if.source           rsp,
   output logic                adv
);
   import sbt_pkg::*;

   typedef struct packed {
      logic              valid;
      logic [DISP_W-1:0] disp;
      logic              bad;
      logic              pixel_last;
      logic              row_last;
   } tag_type;

   rgb_type                         rr_ff, rc_ff;
   rgb_type                         l2, r2;
   rgb_type                         mn2_in, mx2_in;
   rgb_type                         a1_c1_ff, a1_mn1_ff, a1_mx1_ff;
   rgb_type                         a1_c2_ff, a1_mn2_ff, a1_mx2_ff;
   rgb_type                         di1, di2, diff_in, a2_diff_ff;
   logic [NUM_CH-1:0][COST_W-1:0]   term_in, a3_term_ff;
   tag_type                         a1_tag_in, a1_tag_ff, a2_tag_ff, a3_tag_ff;
   logic [SUM_W-1:0]                sum;
   logic [COST_W-1:0]               cost_in;
   logic                            out_valid_ff;
   logic [DISP_W-1:0]               out_disp_ff;
   logic [COST_W-1:0]               out_cost_ff;
   logic                            out_pixel_last_ff;
   logic                            out_row_last_ff;

   assign adv = !out_valid_ff || rsp.ready;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         l2[i] = s1.l2_center ? rc_ff[i] : avg2(rc_ff[i], rd_data[i]);
         r2[i] = s1.r2_center ? rc_ff[i] : avg2(rc_ff[i], rr_ff[i]);
         mn2_in[i] = min3(rc_ff[i], l2[i], r2[i]);
         mx2_in[i] = max3(rc_ff[i], l2[i], r2[i]);
      end
      a1_tag_in.valid      = s1.valid && s1.emit;
      a1_tag_in.disp       = s1.disp;
      a1_tag_in.bad        = s1.bad;
      a1_tag_in.pixel_last = s1.pixel_last;
      a1_tag_in.row_last   = s1.row_last;
   end

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         di1[i] = (a1_c1_ff[i] > a1_mx2_ff[i]) ? a1_c1_ff[i] - a1_mx2_ff[i] :
                  (a1_mn2_ff[i] > a1_c1_ff[i]) ? a1_mn2_ff[i] - a1_c1_ff[i] : '0;
         di2[i] = (a1_c2_ff[i] > a1_mx1_ff[i]) ? a1_c2_ff[i] - a1_mx1_ff[i] :
                  (a1_mn1_ff[i] > a1_c2_ff[i]) ? a1_mn1_ff[i] - a1_c2_ff[i] : '0;
         if (NUMC_W'(i) >= cfg.num_ch) begin
            diff_in[i] = '0;
         end else if (cfg.use_bt) begin
            diff_in[i] = (di1[i] < di2[i]) ? di1[i] : di2[i];
         end else begin
            diff_in[i] = (a1_c1_ff[i] > a1_c2_ff[i]) ? a1_c1_ff[i] - a1_c2_ff[i] :
                                                       a1_c2_ff[i] - a1_c1_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         term_in[i] = cfg.use_sq ? COST_W'(a2_diff_ff[i]) * COST_W'(a2_diff_ff[i]) :
                                   COST_W'(a2_diff_ff[i]);
      end
   end

   always_comb begin
      sum = SUM_W'(a3_term_ff[0]) + SUM_W'(a3_term_ff[1]) + SUM_W'(a3_term_ff[2]);
      if (a3_tag_ff.bad || sum >= SUM_W'(cfg.maxsum)) begin
         cost_in = cfg.maxsum;
      end else begin
         cost_in = sum[COST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s1.valid) begin
            rr_ff <= rc_ff;
            rc_ff <= rd_data;
         end
         a1_c1_ff          <= s1.left.c1;
         a1_mn1_ff         <= s1.left.mn1;
         a1_mx1_ff         <= s1.left.mx1;
         a1_c2_ff          <= rc_ff;
         a1_mn2_ff         <= mn2_in;
         a1_mx2_ff         <= mx2_in;
         a2_diff_ff        <= diff_in;
         a3_term_ff        <= term_in;
         out_disp_ff       <= a3_tag_ff.disp;
         out_cost_ff       <= cost_in;
         out_pixel_last_ff <= a3_tag_ff.pixel_last;
         out_row_last_ff   <= a3_tag_ff.row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_tag_ff    <= '0;
         a2_tag_ff    <= '0;
         a3_tag_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a1_tag_ff    <= a1_tag_in;
         a2_tag_ff    <= a1_tag_ff;
         a3_tag_ff    <= a2_tag_ff;
         out_valid_ff <= a3_tag_ff.valid;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.disparity  = out_disp_ff;
   assign rsp.cost       = out_cost_ff;
   assign rsp.pixel_last = out_pixel_last_ff;
   assign rsp.row_last   = out_row_last_ff;

   a_cost_cap: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_cost_ff <= cfg.maxsum)
      else $error("Output cost exceeds the truncation limit.");

   a_row_pixel: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_row_last_ff |-> out_pixel_last_ff)
      else $error("Row marker appeared on a cost that does not close a pixel.");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(a3_tag_ff) && $stable(a2_tag_ff) && $stable(a1_tag_ff))
      else $error("Cost pipeline moved while the output was stalled.");

endmodule
`default_nettype wire
